FILE: rtl/generation_tagged_slot_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef GENERATION_TAGGED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATION_TAGGED_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// Checks that a consequent follows an antecedent in the same cycle.
`define GTSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in every cycle out of reset.
`define GTSA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

FILE: rtl/gtsa_pkg.sv
package gtsa_pkg;
  localparam logic [2:0] OP_ALLOC      = 3'd0;
  localparam logic [2:0] OP_FREE_H     = 3'd1;
  localparam logic [2:0] OP_FREE_S     = 3'd2;
  localparam logic [2:0] OP_LOOKUP_H   = 3'd3;
  localparam logic [2:0] OP_LOOKUP_S   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam int HANDLE_W = 32;
  localparam int RHANDLE_W = 31;
  localparam int SLOT_W = 8;
  localparam int OFFSET_W = 24;
  localparam int TOTAL_W = 9;
  localparam int UNIT_W = 16;

  localparam logic [1:0] REG_UNIT_SIZE = 2'd0;

  typedef struct packed {
    logic [2:0]          operation;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [RHANDLE_W-1:0] result_handle;
    logic [SLOT_W-1:0]    result_slot;
    logic [OFFSET_W-1:0]  object_offset;
    logic [TOTAL_W-1:0]   used_total;
  } rsp_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    logic [2:0]          operation;
    logic                neg;
    logic [HANDLE_W-2:0] handle;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;
endpackage

FILE: rtl/gtsa_if.sv
interface gtsa_req_if import gtsa_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface gtsa_rsp_if import gtsa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/gtsa_front.sv
module gtsa_front import gtsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  gtsa_req_if.sink req,
  output logic q_valid,
  input  logic q_ready,
  output cmd_t q_cmd
);
  // Two-entry queue toward the back end.
  cmd_t        mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  cmd_t        in_cmd;

  assign req.ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd = mem[rd_ptr];

  always_comb begin
    in_cmd.operation = req.payload.operation;
    in_cmd.neg = req.payload.handle[HANDLE_W-1];
    in_cmd.handle = req.payload.handle[HANDLE_W-2:0];
    in_cmd.slot = req.payload.slot;
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (req.valid && req.ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_valid && q_ready) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, req.valid && req.ready} - {1'b0, q_valid && q_ready};
    end
  end
endmodule

FILE: rtl/gtsa_back.sv
`include "generation_tagged_slot_allocator_core_defines.svh"
module gtsa_back import gtsa_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic [UNIT_W-1:0] unit_size,
  input  logic q_valid,
  output logic q_ready,
  input  cmd_t q_cmd,
  gtsa_rsp_if.source rsp
);
  localparam int IW = $clog2(POOL_DEPTH);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int GW = RHANDLE_W - IW;
  localparam logic [LW-1:0] NONE = {LW{1'b1}};
  localparam logic [GW-1:0] GEN_MAX = {GW{1'b1}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_FIX1  = 3'd4;
  localparam logic [2:0] S_FIX2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Link and generation memories, one row per slot.
  logic [LW-1:0] next_mem [POOL_DEPTH];
  logic [LW-1:0] prev_mem [POOL_DEPTH];
  logic [GW-1:0] gen_mem  [POOL_DEPTH];
  logic          use_mem  [POOL_DEPTH];

  logic [2:0]    state;
  logic [IW:0]   clr_idx;
  logic [LW-1:0] free_head, free_tail, used_head;
  logic [LW-1:0] old_tail;
  logic [CW-1:0] used_count;
  cmd_t          cmd;
  logic [IW-1:0] s;
  logic [LW-1:0] rd_next, rd_prev;
  logic [GW-1:0] rd_gen;
  logic          rd_use;
  logic [LW-1:0] fix_a_idx, fix_a_val, fix_b_idx, fix_b_val;
  logic          fix_a_nxt, fix_b_nxt;
  logic          ok;
  logic [1:0]    status;
  logic [RHANDLE_W-1:0] rhandle;
  logic          out_valid;
  rsp_t          out_data;
  logic [SLOT_W+UNIT_W-1:0] prod;

  logic [IW-1:0] sel_slot;
  logic          range_ok;
  logic [GW-1:0] gen_inc;

  assign q_ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.payload = out_data;

  always_comb begin
    range_ok = 1'b1;
    sel_slot = q_cmd.handle[IW-1:0];
    if ((q_cmd.operation == OP_FREE_S) || (q_cmd.operation == OP_LOOKUP_S)) begin
      sel_slot = q_cmd.slot[IW-1:0];
      range_ok = ({{(32-SLOT_W){1'b0}}, q_cmd.slot} < 32'(POOL_DEPTH));
    end
    if (q_cmd.operation == OP_ALLOC) begin
      sel_slot = free_head[IW-1:0];
    end
  end

  // Generation wrap: the handle field holds exactly GW generation bits.
  assign gen_inc = (rd_gen == GEN_MAX) ? GW'(1) : rd_gen + GW'(1);

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      next_mem[clr_idx[IW-1:0]] <= (clr_idx[IW-1:0] == IW'(POOL_DEPTH - 1)) ?
                                   NONE : LW'(clr_idx) + LW'(1);
      prev_mem[clr_idx[IW-1:0]] <= LW'(clr_idx) - LW'(1);
      gen_mem[clr_idx[IW-1:0]] <= '0;
      use_mem[clr_idx[IW-1:0]] <= 1'b0;
    end else if (state == S_IDLE) begin
      rd_next <= next_mem[sel_slot];
      rd_prev <= prev_mem[sel_slot];
      rd_gen <= gen_mem[sel_slot];
      rd_use <= use_mem[sel_slot];
    end else if (state == S_EXEC && ok) begin
      if (cmd.operation == OP_ALLOC) begin
        use_mem[s] <= 1'b1;
        next_mem[s] <= fix_b_idx;
        prev_mem[s] <= NONE;
        gen_mem[s] <= gen_inc;
      end else if ((cmd.operation == OP_FREE_H) || (cmd.operation == OP_FREE_S)) begin
        use_mem[s] <= 1'b0;
        next_mem[s] <= NONE;
        prev_mem[s] <= old_tail;
      end
    end else if (state == S_FIX1 || state == S_FIX2) begin
      if (state == S_FIX1 && fix_a_idx != NONE) begin
        if (fix_a_nxt) next_mem[fix_a_idx[IW-1:0]] <= fix_a_val;
        else prev_mem[fix_a_idx[IW-1:0]] <= fix_a_val;
      end
      if (state == S_FIX2 && fix_b_idx != NONE) begin
        if (fix_b_nxt) next_mem[fix_b_idx[IW-1:0]] <= fix_b_val;
        else prev_mem[fix_b_idx[IW-1:0]] <= fix_b_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      free_head <= '0;
      free_tail <= LW'(POOL_DEPTH - 1);
      used_head <= NONE;
      used_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (IW+1)'(POOL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cmd <= q_cmd;
            s <= sel_slot;
            ok <= range_ok;
            state <= S_READ;
          end
        end
        S_READ: begin
          status <= ST_INVALID;
          rhandle <= '0;
          fix_a_idx <= NONE;
          fix_b_idx <= NONE;
          fix_a_nxt <= 1'b0;
          fix_b_nxt <= 1'b0;
          fix_a_val <= NONE;
          fix_b_val <= NONE;
          case (cmd.operation)
            OP_ALLOC: begin
              if (used_count >= CW'(POOL_DEPTH) || free_head == NONE) begin
                ok <= 1'b0;
                status <= ST_FULL;
              end else begin
                ok <= 1'b1;
                status <= ST_OK;
                rhandle <= {gen_inc, s};
                free_head <= rd_next;
                if (rd_next == NONE) free_tail <= NONE;
                used_head <= {1'b0, s};
                used_count <= used_count + 1'b1;
                fix_a_idx <= rd_next;
                fix_a_nxt <= 1'b0;
                fix_a_val <= NONE;
                fix_b_idx <= used_head;
                fix_b_nxt <= 1'b0;
                fix_b_val <= {1'b0, s};
              end
            end
            OP_FREE_H, OP_FREE_S, OP_LOOKUP_H: begin
              if ((cmd.operation != OP_FREE_S && (cmd.neg ||
                   cmd.handle[RHANDLE_W-1:IW] != rd_gen)) ||
                  !ok || used_count == '0 || !rd_use) begin
                ok <= 1'b0;
              end else begin
                status <= ST_OK;
                if (cmd.operation != OP_LOOKUP_H) begin
                  old_tail <= free_tail;
                  free_tail <= {1'b0, s};
                  if (free_tail == NONE) free_head <= {1'b0, s};
                  if (used_head == {1'b0, s}) used_head <= rd_next;
                  used_count <= used_count - 1'b1;
                  fix_a_idx <= rd_prev;
                  fix_a_nxt <= 1'b1;
                  fix_a_val <= rd_next;
                  fix_b_idx <= rd_next;
                  fix_b_nxt <= 1'b0;
                  fix_b_val <= rd_prev;
                end
              end
            end
            OP_LOOKUP_S: begin
              if (ok && used_count != '0) status <= ST_OK;
              ok <= ok && used_count != '0;
            end
            default: ok <= 1'b0;
          endcase
          state <= S_EXEC;
        end
        S_EXEC: begin
          prod <= (status == ST_OK) ? SLOT_W'(s) * unit_size : '0;
          state <= S_FIX1;
        end
        S_FIX1: begin
          state <= S_FIX2;
        end
        S_FIX2: begin
          // The old free tail gets its forward link after the unlink.
          if (ok && (cmd.operation == OP_FREE_H || cmd.operation == OP_FREE_S)) begin
            fix_b_idx <= old_tail;
            fix_b_nxt <= 1'b1;
            fix_b_val <= {1'b0, s};
            fix_a_idx <= NONE;
            cmd.operation <= OP_LOOKUP_S;
            state <= S_FIX2;
            ok <= 1'b0;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_data.status <= status;
            out_data.result_handle <= rhandle;
            out_data.result_slot <= (status == ST_OK) ? SLOT_W'(s) : '0;
            out_data.object_offset <= prod[OFFSET_W-1:0];
            out_data.used_total <= TOTAL_W'(used_count);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GTSA_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, used_count <= CW'(POOL_DEPTH), "used count overflow")
  `GTSA_ASSERT_IMPL(a_no_take_busy, clk, rst, q_valid && q_ready, state == S_IDLE, "command taken while busy")
  `GTSA_ASSERT_ALWAYS(a_head_none, clk, rst, (used_count == '0) == (used_head == NONE) || state != S_IDLE, "used head mismatch")
endmodule

FILE: rtl/generation_tagged_slot_allocator_core.sv
// Generational handle pool allocator.
// Requests enter on the req channel (valid/ready, accepted when both are high)
// carrying operation, handle and slot. Each request yields exactly one response
// on the rsp channel with status, result_handle, result_slot, object_offset and
// used_total. A front end classifies requests into a two-entry queue; the back
// end works through the link and generation memories one request at a time.
// For each request the back end steps through memory read, check, offset
// multiply, two link fix-ups plus a third for frees, and the response load.
// It takes a new request only once the response of the last is loaded; the
// single write port of the link memories makes the fix-ups serial.
// After reset the back end sweeps every memory row before it starts on queued
// requests; requests may still be queued meanwhile. unit_size is written over
// the APB-style port at address 0; the user must write it only while idle,
// and the block itself does not enforce this.
// If the receiver stalls, the response is held in the output register; the
// back end finishes one more request and waits for the register to empty,
// and the front queue keeps taking requests until it fills.
module generation_tagged_slot_allocator_core import gtsa_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  gtsa_req_if.sink req,
  gtsa_rsp_if.source rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [UNIT_W-1:0] unit_size;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_UNIT_SIZE) ? {16'd0, unit_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_size <= UNIT_W'(64);
    end else if (psel && penable && pwrite && paddr == REG_UNIT_SIZE) begin
      unit_size <= pwdata[UNIT_W-1:0];
    end
  end

  gtsa_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  gtsa_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
    .clk(clk), .rst(rst), .unit_size(unit_size),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd), .rsp(rsp)
  );
endmodule

FILE: tb/sv/allocator_checker.sv
module allocator_checker import gtsa_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  gtsa_req_if         req_mon,
  gtsa_rsp_if         rsp_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NONE = -1;

  logic [UNIT_W-1:0] unit_bytes;
  int                free_first, free_last, used_first;
  int unsigned       live_count;
  int                link_fwd [POOL_DEPTH];
  int                link_back [POOL_DEPTH];
  longint unsigned   gen_tag [POOL_DEPTH];
  bit                busy [POOL_DEPTH];
  rsp_t              expected_rsp_q [$];

  function automatic bit in_pool(int s);
    return s >= 0 && s < POOL_DEPTH;
  endfunction

  function automatic longint unsigned tag_of(int s);
    return gen_tag[s] * POOL_DEPTH + s;
  endfunction

  function automatic void clear_pool();
    unit_bytes = 16'd64;
    free_first = 0;
    free_last  = POOL_DEPTH - 1;
    used_first = NONE;
    live_count = 0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      link_fwd[i]  = (i == POOL_DEPTH - 1) ? NONE : i + 1;
      link_back[i] = i - 1;
      gen_tag[i]   = 0;
      busy[i]      = 1'b0;
    end
  endfunction

  // Takes the free head, puts it at the front of the used list.
  function automatic int take_slot(output longint unsigned new_tag);
    int s, nxt, old_used;
    new_tag = 0;
    if (live_count >= POOL_DEPTH || !in_pool(free_first)) return NONE;
    s = free_first;
    old_used = used_first;
    nxt = link_fwd[s];
    free_first = in_pool(nxt) ? nxt : NONE;
    used_first = s;
    if (free_first < 0) free_last = NONE;
    live_count++;
    if (in_pool(free_first)) link_back[free_first] = NONE;
    if (in_pool(old_used)) link_back[old_used] = s;
    busy[s] = 1'b1;
    link_fwd[s] = in_pool(old_used) ? old_used : NONE;
    link_back[s] = NONE;
    gen_tag[s] = gen_tag[s] + 1;
    if (tag_of(s) > 64'h7FFF_FFFF) gen_tag[s] = 1;
    new_tag = tag_of(s);
    return s;
  endfunction

  function automatic void return_slot(int s);
    int last_tail, nu, pu;
    last_tail = free_last;
    nu = link_fwd[s];
    pu = link_back[s];
    free_last = s;
    if (!in_pool(last_tail)) free_first = s;
    if (used_first == s) used_first = in_pool(nu) ? nu : NONE;
    live_count--;
    if (in_pool(pu)) link_fwd[pu] = nu;
    if (in_pool(nu)) link_back[nu] = pu;
    if (in_pool(last_tail)) link_fwd[last_tail] = s;
    busy[s] = 1'b0;
    link_fwd[s] = NONE;
    link_back[s] = in_pool(last_tail) ? last_tail : NONE;
  endfunction

  function automatic int resolve_handle(logic [HANDLE_W-1:0] h);
    int s;
    if (h[HANDLE_W-1]) return NONE;
    s = int'(h % POOL_DEPTH);
    if (live_count == 0 || !busy[s] || tag_of(s) != longint'(h)) return NONE;
    return s;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t e;
    int found;
    longint unsigned tag;
    found = NONE;
    tag = 0;
    e = '0;
    e.status = ST_INVALID;
    case (r.operation)
      OP_ALLOC: begin
        found = take_slot(tag);
        e.status = (found >= 0) ? ST_OK : ST_FULL;
      end
      OP_FREE_H, OP_LOOKUP_H: begin
        found = resolve_handle(r.handle);
        if (found >= 0) begin
          e.status = ST_OK;
          if (r.operation == OP_FREE_H) return_slot(found);
        end
      end
      OP_FREE_S: begin
        if (in_pool(r.slot) && live_count > 0 && busy[r.slot]) begin
          found = r.slot;
          e.status = ST_OK;
          return_slot(found);
        end
      end
      OP_LOOKUP_S: begin
        if (in_pool(r.slot) && live_count > 0) begin
          found = r.slot;
          e.status = ST_OK;
        end
      end
      default: ;
    endcase
    if (e.status == ST_OK && r.operation == OP_ALLOC) e.result_handle = tag[RHANDLE_W-1:0];
    if (e.status == ST_OK && found >= 0) begin
      e.result_slot = found[SLOT_W-1:0];
      e.object_offset = OFFSET_W'(longint'(found) * unit_bytes);
    end
    e.used_total = live_count[TOTAL_W-1:0];
    return e;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    clear_pool();
  end

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (rst) begin
      clear_pool();
      expected_rsp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_UNIT_SIZE)
        unit_bytes = pwdata[UNIT_W-1:0];
      if (req_mon.valid && req_mon.ready)
        expected_rsp_q.push_back(predict_response(req_mon.payload));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.payload;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t response with no request outstanding", $realtime);
          errors++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.result_handle !== want.result_handle)
            report_mismatch("result_handle", got.result_handle, want.result_handle);
          if (got.result_slot !== want.result_slot)
            report_mismatch("result_slot", got.result_slot, want.result_slot);
          if (got.object_offset !== want.object_offset)
            report_mismatch("object_offset", got.object_offset, want.object_offset);
          if (got.used_total !== want.used_total)
            report_mismatch("used_total", got.used_total, want.used_total);
        end
      end
    end
    pending = expected_rsp_q.size();
  end
endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import gtsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes past the defined set; the block must reject them.
  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Long enough for the back end to finish a request, with margin.
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  logic [HANDLE_W-1:0] live_handles [$];

  gtsa_req_if req ();
  gtsa_rsp_if rsp ();

  generation_tagged_slot_allocator_core u_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  allocator_checker u_checker (
    .clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The watchdog ends a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver stalls at the rate the current phase asks for.
  always @(posedge clk) rsp.ready <= ($urandom_range(99) >= stall_pct);

  // Handles handed out by successful allocations feed later frees and lookups.
  // Handles that go stale stay useful as requests that must be rejected.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready && rsp.payload.status == ST_OK &&
        rsp.payload.result_handle != '0)
      live_handles.push_back({1'b0, rsp.payload.result_handle});
  end

  // A request is driven at a clock edge and held until the block accepts it.
  // Valid is only lowered when a gap follows, so it never gets two updates in one step.
  task automatic send_request(logic [2:0] op, logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] s);
    req_t r;
    r.operation = op;
    r.handle = h;
    r.slot = s;
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    do @(posedge clk); while (!req.ready);
    requests_sent++;
  endtask

  task automatic write_register(logic [1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Lets the block drain completely so that a register write sees it idle.
  task automatic wait_until_quiet();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle(bit take);
    int idx;
    logic [HANDLE_W-1:0] h;
    if (live_handles.size() == 0) return $urandom_range(32'h7FFF_FFFF);
    idx = $urandom_range(live_handles.size() - 1);
    h = live_handles[idx];
    if (take) live_handles.delete(idx);
    return h;
  endfunction

  // Mostly well-formed traffic on live handles, with some noise mixed in.
  task automatic random_request(int alloc_weight);
    int roll;
    logic [HANDLE_W-1:0] h;
    roll = $urandom_range(99);
    if (roll < alloc_weight) begin
      send_request(OP_ALLOC, $urandom, SLOT_W'($urandom));
    end else if (roll < alloc_weight + 20) begin
      send_request(OP_FREE_H, pick_handle(1'b1), SLOT_W'($urandom));
    end else if (roll < alloc_weight + 30) begin
      send_request(OP_FREE_S, $urandom, SLOT_W'($urandom));
    end else if (roll < alloc_weight + 45) begin
      h = pick_handle(1'b0);
      // Now and then the generation is off by one to hit a stale handle.
      if ($urandom_range(4) == 0) h = h + 32'd256;
      send_request(OP_LOOKUP_H, h, SLOT_W'($urandom));
    end else if (roll < alloc_weight + 55) begin
      send_request(OP_LOOKUP_S, $urandom, SLOT_W'($urandom));
    end else begin
      case ($urandom_range(2))
        0: send_request(3'($urandom_range(OP_RESERVED_LAST, OP_RESERVED_FIRST)), $urandom,
                        SLOT_W'($urandom));
        1: send_request(OP_LOOKUP_H, $urandom, SLOT_W'($urandom));
        default: send_request(OP_FREE_H, $urandom, SLOT_W'($urandom));
      endcase
    end
  endtask

  task automatic run_phase(int idle, int stall, int count, bit hold_midway);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      // With hold_midway set, the sender stops once until every response has come back.
      if (hold_midway && i == count / 2) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_request(35);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty pool, the first allocations, and every way a
    // handle or slot can be refused. Slots 0, 1 and 2 get generation 1.
    write_register(REG_UNIT_SIZE, 32'd65535);
    send_request(OP_LOOKUP_S, '0, 8'd0);
    send_request(OP_FREE_H, 32'd256, 8'd0);
    send_request(OP_FREE_S, '0, 8'd0);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, '1, '1);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_LOOKUP_H, 32'd256, '0);
    send_request(OP_LOOKUP_H, 32'd512, '0);
    send_request(OP_LOOKUP_H, 32'hFFFF_FF00, '0);
    send_request(OP_LOOKUP_H, 32'h8000_0000, '0);
    send_request(OP_LOOKUP_H, 32'h7FFF_FFFF, '0);
    send_request(OP_FREE_H, 32'd257, '0);
    send_request(OP_FREE_H, 32'd257, '0);
    send_request(OP_FREE_S, '0, 8'd2);
    send_request(OP_FREE_S, '0, 8'd2);
    send_request(OP_LOOKUP_S, '1, 8'd255);
    send_request(OP_LOOKUP_S, '0, 8'd0);
    send_request(OP_RESERVED_FIRST, '1, '1);
    send_request(OP_RESERVED_LAST - 3'd1, '0, '0);
    send_request(OP_RESERVED_LAST, 32'd256, 8'd0);
    send_request(OP_ALLOC, '0, '0);
    wait_until_quiet();

    // Fill the pool and push past it to see the full response.
    write_register(REG_UNIT_SIZE, 32'd1);
    stall_pct = 30;
    for (int i = 0; i < 260; i++) send_request(OP_ALLOC, $urandom, SLOT_W'($urandom));
    send_request(OP_LOOKUP_S, '0, 8'd255);
    wait_until_quiet();

    run_phase(0, 0, 260, 1'b0);
    wait_until_quiet();
    write_register(REG_UNIT_SIZE, 32'd64);
    run_phase(58, 0, 260, 1'b1);
    wait_until_quiet();
    write_register(REG_UNIT_SIZE, 32'($urandom_range(65535, 1)));
    run_phase(0, 58, 260, 1'b0);
    wait_until_quiet();
    write_register(REG_UNIT_SIZE, 32'd65535);
    run_phase(30, 30, 260, 1'b0);

    wait_until_quiet();
    $display("Sent %0d requests over directed checks, a pool fill past full and four",
             requests_sent);
    $display("random phases with sender gaps and receiver stalls, unit size 1 to 65535.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
